@@ rtl/telemetry_frame_parser_crc8_assert.svh @@
// Assertion macros used by the telemetry frame parser (tfp_parser)
`ifndef TELEMETRY_FRAME_PARSER_CRC8_ASSERT_SVH
`define TELEMETRY_FRAME_PARSER_CRC8_ASSERT_SVH

// clocked check, held off while reset is high
`define TFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define TFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/tfp_pkg.sv @@
// Types, constants and the CRC-8 step for the telemetry frame parser
package tfp_pkg;

  localparam int MAX_PAYLOAD = 255;
  localparam int HDR_LEN_I   = 10;

  localparam logic [8:0]  HDR_LEN     = 9'(HDR_LEN_I);
  localparam logic [15:0] LEN_MIN     = 16'(HDR_LEN_I);
  localparam logic [15:0] LEN_MAX     = 16'(HDR_LEN_I + MAX_PAYLOAD);
  localparam logic [7:0]  CRC_POLY    = 8'h07;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE_MASK    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE_VERSION = CFG_INDEX_W'(2);

  localparam logic [7:0] SYNC_BYTE_RST    = 8'h3C;
  localparam logic [7:0] TYPE_MASK_RST    = 8'hF8;
  localparam logic [7:0] TYPE_VERSION_RST = 8'h20;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [6:0] {
    PH_SYNC = 7'b0000001,
    PH_TYPE = 7'b0000010,
    PH_LEN  = 7'b0000100,
    PH_OBJ  = 7'b0001000,
    PH_INST = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_CRC  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] type_mask;
    logic [7:0] type_version;
  } tfp_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  message_type;
    logic [8:0]  frame_length;
    logic [31:0] object_id;
    logic [15:0] instance_id;
    logic        crc_ok;
  } tfp_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

@@ rtl/tfp_in_stage.sv @@
// Input register: holds one received word until the parser takes it
module tfp_in_stage import tfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       step,
  output logic [7:0] held_byte
);

  logic full;

  assign in_stall = full && !advance;
  assign step     = full && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

endmodule

@@ rtl/tfp_parser.sv @@
// Frame parser: phase tracking, header capture and CRC-8 for one word per cycle while step is high
`include "telemetry_frame_parser_crc8_assert.svh"

module tfp_parser import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  c,
  input  tfp_cfg_t    cfg,
  output logic        res_valid,
  output tfp_result_t res
);

  phase_t      phase, phase_next;
  logic [7:0]  crc, crc_next;
  logic [7:0]  count, count_next;
  logic [7:0]  held_type, held_type_next;
  logic [8:0]  held_length, held_length_next;
  logic [31:0] held_object, held_object_next;
  logic [15:0] held_instance, held_instance_next;
  logic [15:0] full_length;
  logic [7:0]  crc_step;
  logic [9:0]  plen;
  logic [9:0]  count_inc;

  assign crc_step    = crc8_byte(crc, c);
  assign full_length = {c, held_length[7:0]};
  assign plen        = {1'b0, held_length} - {1'b0, HDR_LEN};
  assign count_inc   = {2'b00, count} + 10'd1;

  always_comb begin
    phase_next         = phase;
    crc_next           = crc;
    count_next         = count;
    held_type_next     = held_type;
    held_length_next   = held_length;
    held_object_next   = held_object;
    held_instance_next = held_instance;
    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.message_type   = held_type;
    res.frame_length   = held_length;
    res.object_id      = held_object;
    res.instance_id    = held_instance;
    res.crc_ok         = 1'b0;
    case (phase)
      PH_TYPE: begin
        crc_next = crc_step;
        if ((c & cfg.type_mask) == cfg.type_version) begin
          held_type_next = c;
          count_next     = 8'd0;
          phase_next     = PH_LEN;
        end else begin
          phase_next = PH_SYNC;
        end
      end
      PH_LEN: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          held_length_next = {1'b0, c};
          count_next       = 8'd1;
        end else begin
          held_length_next = full_length[8:0];
          count_next       = 8'd0;
          if (full_length < LEN_MIN || full_length > LEN_MAX) begin
            phase_next = PH_SYNC;
          end else begin
            phase_next = PH_OBJ;
          end
        end
      end
      PH_OBJ: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          held_object_next = {24'd0, c};
        end else begin
          held_object_next = held_object | ({24'd0, c} << {count[1:0], 3'b000});
        end
        if (count >= 8'd3) begin
          count_next = 8'd0;
          phase_next = PH_INST;
        end else begin
          count_next = count + 8'd1;
        end
      end
      PH_INST: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          held_instance_next = {8'd0, c};
          count_next         = 8'd1;
        end else begin
          held_instance_next = {c, held_instance[7:0]};
          count_next         = 8'd0;
          phase_next         = (held_length == HDR_LEN) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_next          = crc_step;
        res_valid         = step;
        res.payload_byte  = c;
        res.payload_index = count;
        if (count_inc >= plen) begin
          count_next = 8'd0;
          phase_next = PH_CRC;
        end else begin
          count_next = count + 8'd1;
        end
      end
      PH_CRC: begin
        res_valid  = step;
        res.kind   = KIND_END;
        res.crc_ok = (crc == c);
        phase_next = PH_SYNC;
      end
      default: begin
        phase_next = PH_SYNC;
        if (c == cfg.sync_byte) begin
          crc_next   = crc8_byte(8'd0, c);
          phase_next = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      crc           <= 8'd0;
      count         <= 8'd0;
      held_type     <= 8'd0;
      held_length   <= 9'd0;
      held_object   <= 32'd0;
      held_instance <= 16'd0;
    end else if (step) begin
      phase         <= phase_next;
      crc           <= crc_next;
      count         <= count_next;
      held_type     <= held_type_next;
      held_length   <= held_length_next;
      held_object   <= held_object_next;
      held_instance <= held_instance_next;
    end
  end

  `TFP_ASSERT(a_end_sync, (step && phase == PH_CRC) |=> phase == PH_SYNC, "end not to sync")
  `TFP_ASSERT(a_data_res, (step && phase == PH_DATA) |-> res_valid, "payload word lost")
  `TFP_ASSERT(a_obj_count, (phase == PH_OBJ) |-> (count <= 8'd3), "object count out of range")
  `TFP_ASSERT(a_len_lo, (phase == PH_DATA) |-> (held_length > HDR_LEN), "short length")
  `TFP_ASSERT(a_len_hi, (phase == PH_DATA) |-> (held_length <= LEN_MAX[8:0]), "long length")

endmodule

@@ rtl/tfp_out_stage.sv @@
// Result register: holds one result word until the consumer takes it
module tfp_out_stage import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  tfp_result_t res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output tfp_result_t out_res
);

  assign advance = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

@@ rtl/telemetry_frame_parser_crc8.sv @@
// Telemetry frame parser with CRC-8 check, top level
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  rx_byte
//   output   out        out_valid/out_stall  kind .. crc_ok
//   config   in         cfg_we               cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; a word held in the
// input register is parsed on step, and its result is registered for out_valid.
// The parse step (phase decode plus one CRC-8 byte update) sets the cycle.
// Synchronous reset clears the parse phase, counters, valid flags and
// restores the register defaults; no clearing pass.
// While out_stall holds a result the input register keeps at most one word.
module telemetry_frame_parser_crc8 import tfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [7:0]             payload_byte,
  output logic [7:0]             payload_index,
  output logic [7:0]             message_type,
  output logic [8:0]             frame_length,
  output logic [31:0]            object_id,
  output logic [15:0]            instance_id,
  output logic                   crc_ok,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  tfp_cfg_t    cfg;
  tfp_result_t res;
  tfp_result_t out_res;
  logic        res_valid;
  logic        advance;
  logic        step;
  logic [7:0]  held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte    <= SYNC_BYTE_RST;
      cfg.type_mask    <= TYPE_MASK_RST;
      cfg.type_version <= TYPE_VERSION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_BYTE:    cfg.sync_byte    <= cfg_data;
        REG_TYPE_MASK:    cfg.type_mask    <= cfg_data;
        REG_TYPE_VERSION: cfg.type_version <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tfp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .step      (step),
    .held_byte (held_byte)
  );

  tfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .c         (held_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  tfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind          = out_res.kind;
  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign message_type  = out_res.message_type;
  assign frame_length  = out_res.frame_length;
  assign object_id     = out_res.object_id;
  assign instance_id   = out_res.instance_id;
  assign crc_ok        = out_res.crc_ok;

endmodule
